// ===== src/fwca_pkg.sv =====
`default_nettype none

package fwca_pkg;

	localparam int COORD_BITS = 12;
	localparam int SPEED_BITS = 3;
	localparam int STEP_BITS  = 5;

	localparam logic [SPEED_BITS-1:0] SPEED_MAX  = 3'd6;
	localparam logic [STEP_BITS-1:0]  STEP_PIXELS = 5'd5;

	localparam logic [2:0] JOY_SELECT = 3'd0;
	localparam logic [2:0] JOY_LEFT   = 3'd1;
	localparam logic [2:0] JOY_RIGHT  = 3'd2;
	localparam logic [2:0] JOY_UP     = 3'd3;
	localparam logic [2:0] JOY_DOWN   = 3'd4;

	localparam logic [1:0] VAL_RELEASE = 2'd0;
	localparam logic [1:0] VAL_PRESS   = 2'd1;
	localparam logic [1:0] VAL_REPEAT  = 2'd2;

	localparam logic [1:0] REG_KEYPAD_MODE  = 2'd0;
	localparam logic [1:0] REG_SCREEN_MAX_X = 2'd1;
	localparam logic [1:0] REG_SCREEN_MAX_Y = 2'd2;

	localparam logic REPORT_CURSOR = 1'b0;
	localparam logic REPORT_KEY    = 1'b1;

	localparam logic [COORD_BITS-1:0] SCREEN_MAX_X_RESET = 12'd599;
	localparam logic [COORD_BITS-1:0] SCREEN_MAX_Y_RESET = 12'd799;

	typedef logic [COORD_BITS-1:0] coord_t;

	// Moves a coordinate by a signed step and holds it inside 0 .. lim.
	function automatic coord_t clamp_move(input coord_t pos, input logic [STEP_BITS-1:0] amt,
		input logic neg, input coord_t lim);
		logic signed [COORD_BITS+1:0] sum;
		logic signed [COORD_BITS+1:0] delta;
		begin
			delta = $signed({{(COORD_BITS+2-STEP_BITS){1'b0}}, amt});
			sum = $signed({2'b00, pos});
			sum = neg ? (sum - delta) : (sum + delta);
			if (sum < 0) begin
				clamp_move = '0;
			end else if (sum > $signed({2'b00, lim})) begin
				clamp_move = lim;
			end else begin
				clamp_move = sum[COORD_BITS-1:0];
			end
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/five_way_cursor_accelerator.sv =====
// Five-way joystick cursor accelerator.
// Key events enter on the s_ stream channel; reports leave on the m_ stream
// channel. In mouse mode every key event produces a cursor report carrying the
// clamped position and the latched button; arrows move the cursor and repeated
// arrows accelerate up to six steps of five pixels. In keypad mode known keys
// are forwarded as key reports. The first event after a mode change and every
// non-key event are consumed without a report.
// Configuration registers (mode, screen limits) are written on the cfg_
// channel, which is always ready; write them only while the block is idle.
// A request passes through the input register; the position and speed update
// then lands in the output register. One request is accepted every cycle while
// the output register is not stalled, as the state update between the two
// registers is combinational.
// When the receiver stalls, the output register holds its request and the
// input register fills; s_tready drops only when both are occupied.
// Reset clears the position, speeds, button and mode, and sets the screen
// limits to 599 by 799.
`default_nettype none

module five_way_cursor_accelerator
	import fwca_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // key[2:0], key_value[4:3], zeros
	input  wire logic        s_tuser,   // is_key_event
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // cursor_x[11:0], cursor_y[23:12], left_down[24],
	                                    // key_id[27:25], key_pressed[28], key_repeat[29], zeros
	output logic             m_tuser,   // report_kind
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	logic                  valid_s1;
	logic                  is_key_s1;
	logic [2:0]            key_s1;
	logic [1:0]            val_s1;

	logic                  keypad_mode_q;
	coord_t                max_x_q;
	coord_t                max_y_q;
	coord_t                pos_x_q;
	coord_t                pos_y_q;
	logic [SPEED_BITS-1:0] speed_q [4];
	logic                  button_q;
	logic                  prev_mode_q;

	logic                  out_valid_q;
	logic                  out_kind_q;
	logic [29:0]           out_data_q;

	logic                  advance;
	logic                  cfg_fire;
	logic                  is_arrow;
	logic [1:0]            dir;
	logic [SPEED_BITS-1:0] spd_cur;
	logic [SPEED_BITS-1:0] spd_next;
	logic [STEP_BITS-1:0]  amt;
	logic [STEP_BITS-1:0]  amt_x;
	logic [STEP_BITS-1:0]  amt_y;
	coord_t                new_x;
	coord_t                new_y;
	logic                  new_button;
	logic                  live;
	logic                  emit_cursor;
	logic                  emit_key;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign is_arrow = (key_s1 == JOY_LEFT) || (key_s1 == JOY_RIGHT) ||
		(key_s1 == JOY_UP) || (key_s1 == JOY_DOWN);
	assign dir      = key_s1[1:0] - 2'd1;
	assign spd_cur  = speed_q[dir];

	always_comb begin
		case (val_s1)
			VAL_RELEASE: spd_next = '0;
			VAL_PRESS:   spd_next = 3'd1;
			default:     spd_next = (spd_cur < SPEED_MAX) ? spd_cur + 3'd1 : spd_cur;
		endcase
		amt = {spd_next, 2'b00} + {2'b00, spd_next};
	end

	assign amt_x = ((key_s1 == JOY_LEFT) || (key_s1 == JOY_RIGHT)) ? amt : '0;
	assign amt_y = ((key_s1 == JOY_UP) || (key_s1 == JOY_DOWN)) ? amt : '0;
	assign new_x = clamp_move(pos_x_q, amt_x, key_s1 == JOY_LEFT, max_x_q);
	assign new_y = clamp_move(pos_y_q, amt_y, key_s1 == JOY_UP, max_y_q);
	assign new_button = button_q ^ (key_s1 == JOY_SELECT);

	// An event is live only when the mode has not changed since the last one.
	assign live        = valid_s1 && advance && is_key_s1 && (keypad_mode_q == prev_mode_q);
	assign emit_cursor = live && !keypad_mode_q;
	assign emit_key    = live && keypad_mode_q && (key_s1 <= JOY_DOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			is_key_s1 <= s_tuser;
			key_s1    <= s_tdata[2:0];
			val_s1    <= s_tdata[4:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keypad_mode_q <= 1'b0;
			max_x_q       <= SCREEN_MAX_X_RESET;
			max_y_q       <= SCREEN_MAX_Y_RESET;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			for (int i = 0; i < 4; i++) begin
				speed_q[i] <= '0;
			end
			button_q      <= 1'b0;
			prev_mode_q   <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				prev_mode_q <= keypad_mode_q;
			end
			if (emit_cursor) begin
				pos_x_q  <= new_x;
				pos_y_q  <= new_y;
				button_q <= new_button;
				if (is_arrow) begin
					speed_q[dir] <= spd_next;
				end
			end
			if (cfg_fire) begin
				case (cfg_index)
					REG_KEYPAD_MODE: begin
						keypad_mode_q <= cfg_data[0];
						button_q      <= 1'b0;
					end
					REG_SCREEN_MAX_X: max_x_q <= cfg_data;
					REG_SCREEN_MAX_Y: max_y_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit_cursor || emit_key;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_cursor) begin
			out_kind_q <= REPORT_CURSOR;
			out_data_q <= {5'b0, new_button, new_y, new_x};
		end else if (emit_key) begin
			out_kind_q <= REPORT_KEY;
			out_data_q <= {val_s1 == VAL_REPEAT, val_s1 != VAL_RELEASE, key_s1, 1'b0,
				{COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_data_q};

endmodule

`default_nettype wire
